[rtl/psr_pkg.sv]
package psr_pkg;

  // Default build values
  localparam int DELAY_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Loop values are signed Q2.16
  localparam int LOOP_W  = 18;
  // Signed operand A of the shared multiplier
  localparam int MUL_A_W = 19;

  // Configuration port
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCITE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY    = 3'd4;

  localparam logic [17:0] DELAY_RESET     = 18'd18618;
  localparam logic [15:0] DAMP_RESET      = 16'd32768;
  localparam logic [15:0] LOOP_GAIN_RESET = 16'd63570;
  localparam logic [15:0] EXCITE_RESET    = 16'd26214;
  localparam logic [15:0] DRY_RESET       = 16'd7864;

  // Noise generator
  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;
  localparam logic [31:0] SEED_RESET = 32'h0123_4567;
  localparam logic [15:0] NOISE_AMP  = 16'd58982;

  // Saturation limits in Q2.16
  localparam int LOOP_LIMIT = 78643;
  localparam int LP_LIMIT   = 131071;
  localparam int MIX_LIMIT  = 65536;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LERP,
    ST_DRY,
    ST_DAMP,
    ST_NOISE,
    ST_LOOP,
    ST_WRITE,
    ST_DONE
  } psr_state_t;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_READ,
    STEP_LERP,
    STEP_DRY,
    STEP_DAMP,
    STEP_NOISE,
    STEP_LOOP,
    STEP_WRITE
  } psr_step_t;

  typedef struct packed {
    logic      take;
    psr_step_t step;
    logic      emit;
  } psr_cmd_t;

  typedef struct packed {
    logic out_free;
  } psr_status_t;

  typedef struct packed {
    logic [17:0] delay_q8;
    logic [15:0] damping_coef;
    logic [15:0] loop_gain;
    logic [15:0] excite_gain;
    logic [15:0] dry_gain;
  } psr_cfg_t;

endpackage

[rtl/psr_in_if.sv]
interface psr_in_if import psr_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          pluck;

  modport source (output valid, output left_sample, output right_sample, output pluck,
                  input ready);
  modport sink (input valid, input left_sample, input right_sample, input pluck,
                output ready);
endinterface

[rtl/psr_out_if.sv]
interface psr_out_if import psr_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface

[rtl/psr_ctrl.sv]
module psr_ctrl import psr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  psr_status_t status,
  output psr_cmd_t    cmd
);

  psr_state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance through the fixed schedule of one word
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_LERP;
      ST_LERP:  state_nxt = ST_DRY;
      ST_DRY:   state_nxt = ST_DAMP;
      ST_DAMP:  state_nxt = ST_NOISE;
      ST_NOISE: state_nxt = ST_LOOP;
      ST_LOOP:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE:  if (status.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    cmd.take = in_ready && in_valid;
    cmd.emit = 1'b0;
    case (state_r)
      ST_READ:  cmd.step = STEP_READ;
      ST_LERP:  cmd.step = STEP_LERP;
      ST_DRY:   cmd.step = STEP_DRY;
      ST_DAMP:  cmd.step = STEP_DAMP;
      ST_NOISE: cmd.step = STEP_NOISE;
      ST_LOOP:  cmd.step = STEP_LOOP;
      ST_WRITE: cmd.step = STEP_WRITE;
      ST_DONE: begin
        cmd.step = STEP_NONE;
        cmd.emit = status.out_free;
      end
      default:  cmd.step = STEP_NONE;
    endcase
  end

  a_take_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> state_r == ST_READ)
    else $error("accepted word did not start the read step");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !status.out_free) |=> state_r == ST_DONE)
    else $error("result dropped while output register was full");

endmodule

[rtl/psr_datapath.sv]
module psr_datapath import psr_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  psr_cfg_t                      cfg,
  input  psr_cmd_t                      cmd,
  output psr_status_t                   status,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  input  logic                          in_pluck,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_sample
);

  localparam int AW      = $clog2(DELAY_DEPTH);
  localparam int CW      = ((AW + 9) > 18) ? AW + 10 : 19;
  localparam int MBW     = (SAMPLE_BITS > 17) ? SAMPLE_BITS : 17;
  localparam int PW      = MUL_A_W + MBW;
  localparam int SUMW    = SAMPLE_BITS + 1;
  localparam int MICX    = 26;
  localparam int MIC_SHL = (SAMPLE_BITS <= 16) ? 16 - SAMPLE_BITS : 0;
  localparam int MIC_SHR = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;

  localparam logic [CW-1:0]  DMIN = CW'(512);
  localparam logic [CW-1:0]  DMAX = CW'((DELAY_DEPTH - 2) * 256);
  localparam logic [CW-1:0]  SPAN = CW'(DELAY_DEPTH * 256);
  localparam logic [AW-1:0]  LAST = AW'(DELAY_DEPTH - 1);
  localparam logic [MBW-1:0] FULL = MBW'((1 << (SAMPLE_BITS - 1)) - 1);

  // Clip a loop sum to +-lim
  function automatic logic signed [LOOP_W-1:0] sat_loop(input logic signed [19:0] v,
                                                         input int lim);
    logic signed [LOOP_W-1:0] r;
    if (v > lim) r = LOOP_W'(lim);
    else if (v < -lim) r = LOOP_W'(-lim);
    else r = v[LOOP_W-1:0];
    return r;
  endfunction

  // Delay line
  logic signed [LOOP_W-1:0] mem [DELAY_DEPTH];

  logic signed [LOOP_W-1:0] mic_r;
  logic                     pluck_r;
  logic [CW-1:0]            dly_r;
  logic [AW-1:0]            wp_r;
  logic                     wrapped_r;
  logic [AW-1:0]            burst_r;
  logic [31:0]              seed_r;
  logic                     noise_on_r;
  logic signed [LOOP_W-1:0] rd0_r, rd1_r;
  logic                     v0_r, v1_r;
  logic [7:0]               f_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [19:0]       exc_r;
  logic signed [LOOP_W-1:0] d_r;
  logic signed [LOOP_W-1:0] ymix_r;
  logic signed [LOOP_W-1:0] lp_r;
  logic signed [LOOP_W-1:0] y_r;
  logic                     out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;

  // Mic value and clamped delay at take
  logic signed [SUMW-1:0]   mic_sum;
  logic signed [MICX-1:0]   mic_x;
  logic signed [MICX-1:0]   mic_s;
  logic [CW-1:0]            dly_in, dly_c;

  always_comb begin
    mic_sum = SUMW'(in_left) + SUMW'(in_right);
    mic_x   = MICX'(mic_sum);
    mic_s   = (mic_x <<< MIC_SHL) >>> MIC_SHR;
    dly_in  = CW'(cfg.delay_q8);
    if (dly_in < DMIN) dly_c = DMIN;
    else if (dly_in > DMAX) dly_c = DMAX;
    else dly_c = dly_in;
  end

  // Read position: one compare and subtract folds the wrap
  logic [CW-1:0] rsum, rpos;
  logic [AW-1:0] i0, i1;

  always_comb begin
    rsum = CW'({wp_r, 8'd0}) + SPAN - dly_r;
    rpos = (rsum >= SPAN) ? rsum - SPAN : rsum;
    i0   = rpos[AW+7:8];
    i1   = (i0 == LAST) ? '0 : i0 + 1'b1;
  end

  // Unwritten entries read as zero
  logic signed [LOOP_W-1:0] rd0m, rd1m;
  assign rd0m = v0_r ? rd0_r : '0;
  assign rd1m = v1_r ? rd1_r : '0;

  // Product views and sums
  logic signed [19:0]       p16, p8;
  logic signed [19:0]       lerp_sum, lp_sum, ysum, vsum;
  logic signed [LOOP_W-1:0] v_sat;
  logic signed [16:0]       noise_c;
  logic signed [PW-1:0]     prod_adj;
  logic signed [PW-1:0]     out_w;

  always_comb begin
    p16      = 20'(prod_r >>> 16);
    p8       = 20'(prod_r >>> 8);
    lerp_sum = 20'(rd0m) + p8;
    lp_sum   = 20'(lp_r) + p16;
    ysum     = 20'(lp_r) + 20'(ymix_r);
    vsum     = exc_r + p16;
    v_sat    = sat_loop(vsum, LOOP_LIMIT);
    noise_c  = seed_r[31:15];
    prod_adj = prod_r + PW'(prod_r[PW-1] ? 32'h0000_FFFF : 32'h0);
    out_w    = prod_adj >>> 16;
  end

  // Select multiplier operands for the current step
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MBW-1:0]     mul_b;

  always_comb begin
    case (cmd.step)
      STEP_READ: begin
        mul_a = MUL_A_W'(mic_r);
        mul_b = MBW'(cfg.excite_gain);
      end
      STEP_LERP: begin
        mul_a = MUL_A_W'(rd1m) - MUL_A_W'(rd0m);
        mul_b = MBW'(f_r);
      end
      STEP_DRY: begin
        mul_a = MUL_A_W'(mic_r);
        mul_b = MBW'(cfg.dry_gain);
      end
      STEP_DAMP: begin
        mul_a = MUL_A_W'(d_r) - MUL_A_W'(lp_r);
        mul_b = MBW'(cfg.damping_coef);
      end
      STEP_NOISE: begin
        mul_a = MUL_A_W'(noise_c);
        mul_b = MBW'(NOISE_AMP);
      end
      STEP_LOOP: begin
        mul_a = MUL_A_W'(lp_r);
        mul_b = MBW'(cfg.loop_gain);
      end
      STEP_WRITE: begin
        mul_a = MUL_A_W'(y_r);
        mul_b = FULL;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared multiplier; hold the product while no step runs
  always_ff @(posedge clk) begin
    if (cmd.step != STEP_NONE) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // Delay line ports: two registered reads, one write
  always_ff @(posedge clk) begin
    if (cmd.step == STEP_READ) begin
      rd0_r <= mem[i0];
      rd1_r <= mem[i1];
    end
    if (cmd.step == STEP_WRITE) begin
      mem[wp_r] <= v_sat;
    end
  end

  // Step payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mic_r   <= mic_s[LOOP_W-1:0];
      pluck_r <= in_pluck;
      dly_r   <= dly_c;
    end
    case (cmd.step)
      STEP_READ: begin
        v0_r <= wrapped_r || (i0 < wp_r);
        v1_r <= wrapped_r || (i1 < wp_r);
        f_r  <= rpos[7:0];
      end
      STEP_LERP:  exc_r  <= p16;
      STEP_DRY:   d_r    <= lerp_sum[LOOP_W-1:0];
      STEP_DAMP:  ymix_r <= p16[LOOP_W-1:0];
      STEP_LOOP: begin
        if (noise_on_r) exc_r <= vsum;
        y_r <= sat_loop(ysum, MIX_LIMIT);
      end
      default: ;
    endcase
  end

  // Loop state: pointer, fill mark, low-pass, burst and noise seed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      wrapped_r  <= 1'b0;
      lp_r       <= '0;
      burst_r    <= '0;
      seed_r     <= SEED_RESET;
      noise_on_r <= 1'b0;
    end else begin
      case (cmd.step)
        STEP_READ: begin
          if (pluck_r) burst_r <= dly_r[AW+7:8];
        end
        STEP_LERP: begin
          noise_on_r <= (burst_r != '0);
          if (burst_r != '0) begin
            seed_r  <= seed_r * LCG_MUL + LCG_ADD;
            burst_r <= burst_r - 1'b1;
          end
        end
        STEP_NOISE: lp_r <= sat_loop(lp_sum, LP_LIMIT);
        STEP_WRITE: begin
          if (wp_r == LAST) begin
            wp_r      <= '0;
            wrapped_r <= 1'b1;
          end else begin
            wp_r <= wp_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample_r <= out_w[SAMPLE_BITS-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign status.out_free = !out_valid_r || out_ready;

  a_wp_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step != STEP_WRITE |=> $stable(wp_r))
    else $error("write pointer moved outside the write step");

  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    burst_r <= (DELAY_DEPTH - 2))
    else $error("noise burst count beyond the longest delay");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit))
    else $error("output word raised without an emit");

endmodule

[rtl/plucked_string_resonator.sv]
// Channel  Dir  Handshake          Word
// in_ch    in   valid / ready      left_sample, right_sample, pluck
// out_ch   out  valid / ready      out_sample
// cfg_     in   cfg_we (no stall)  cfg_index, cfg_wdata
//
// Each word runs through a fixed schedule of seven steps around one shared
// multiplier, which carries the seven products of the loop in turn.
// A finished word waits in the output register; the next word is held off
// through the schedule, and after it only while that register is still full.
// Reset (rst_n low, synchronous) is ready at once: delay line entries that were
// never written since reset read as zero through a fill mark, no clearing pass.
module plucked_string_resonator import psr_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  psr_in_if.sink               in_ch,
  psr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  psr_cfg_t    cfg_r;
  psr_cmd_t    cmd;
  psr_status_t status;
  logic        in_ready;

  // Configuration registers; writes beyond the list drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_q8     <= DELAY_RESET;
      cfg_r.damping_coef <= DAMP_RESET;
      cfg_r.loop_gain    <= LOOP_GAIN_RESET;
      cfg_r.excite_gain  <= EXCITE_RESET;
      cfg_r.dry_gain     <= DRY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELAY:  cfg_r.delay_q8     <= cfg_wdata;
        CFG_DAMP:   cfg_r.damping_coef <= cfg_wdata[15:0];
        CFG_LOOP:   cfg_r.loop_gain    <= cfg_wdata[15:0];
        CFG_EXCITE: cfg_r.excite_gain  <= cfg_wdata[15:0];
        CFG_DRY:    cfg_r.dry_gain     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = in_ready;

  psr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  psr_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .status     (status),
    .in_left    (in_ch.left_sample),
    .in_right   (in_ch.right_sample),
    .in_pluck   (in_ch.pluck),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_sample (out_ch.out_sample)
  );

endmodule
